// File: rtl/core/xalu_pkg.sv
// Package for the x86 integer ALU: operation codes, flag and result types.
// No dependencies; imported by xalu_exec and x86_integer_alu_with_flags.
`default_nettype none

package xalu_pkg;

    // Operation codes carried in req_type
    typedef enum logic [3:0] {
        OP_ADD  = 4'd0,
        OP_OR   = 4'd1,
        OP_ADC  = 4'd2,
        OP_SBB  = 4'd3,
        OP_AND  = 4'd4,
        OP_SUB  = 4'd5,
        OP_XOR  = 4'd6,
        OP_CMP  = 4'd7,
        OP_TEST = 4'd8,
        OP_INC  = 4'd9,
        OP_DEC  = 4'd10
    } op_t;

    localparam int unsigned DATA_W = 16;

    // Input and output transfer payload widths
    localparam int unsigned S_TDATA_W = 40;
    localparam int unsigned M_TDATA_W = 24;

    // Nibble carry position
    localparam int unsigned AF_BIT = 4;

    // Arithmetic flags, CF in the lowest bit
    typedef struct packed {
        logic of;
        logic sf;
        logic zf;
        logic af;
        logic pf;
        logic cf;
    } flags_t;

    // One operation as held in the input stage
    typedef struct packed {
        logic [DATA_W-1:0] src_value;
        logic [DATA_W-1:0] dst_value;
        logic              wide;
        logic [3:0]        req_type;
    } alu_req_t;

    // One result as held in the output stage
    typedef struct packed {
        flags_t            flags;
        logic              write_back;
        logic [DATA_W-1:0] result;
    } alu_res_t;

endpackage

`default_nettype wire

// File: rtl/core/x86_integer_alu_with_flags.sv
// Top level of the x86 integer ALU: stream ports, input and result stages, flags register.
// Depends on xalu_pkg and xalu_exec.
//
//  channel | dir | tdata fields (low bit up)
//  --------+-----+-------------------------------------------------------------
//  s_      | in  | req_type[3:0] wide[4] dst_value[20:5] src_value[36:21], 0-pad
//  m_      | out | result[15:0] write_back[16] cf[17] pf[18] af[19] zf[20]
//          |     | sf[21] of[22], 0-pad
//
// One operation per cycle sustained while m_tready stays high; an item passes through the
// input stage register and then the result stage register before m_tvalid rises.
// The flags register is the only loop: it is written as an item moves from the
// input stage to the result stage, and the next item reads it while in the input stage.
// aresetn (synchronous) clears both stage valids and the flags.
// A stall on m_tready holds the result stage; the input stage still takes one item.
`default_nettype none

module x86_integer_alu_with_flags (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  wire                               s_tvalid,
    output logic                              s_tready,
    // req_type[3:0], wide[4], dst_value[20:5], src_value[36:21]
    input  wire  [xalu_pkg::S_TDATA_W-1:0]    s_tdata,
    output logic                              m_tvalid,
    input  wire                               m_tready,
    // result[15:0], write_back[16], carry[17], parity[18], aux[19],
    // zero[20], sign[21], overflow[22]
    output logic [xalu_pkg::M_TDATA_W-1:0]    m_tdata
);
    import xalu_pkg::*;

    logic     in_valid_reg;
    logic     in_valid_next;
    alu_req_t in_req_reg;
    logic     out_valid_reg;
    logic     out_valid_next;
    alu_res_t out_res_reg;
    flags_t   flags_reg;
    alu_res_t exec_res;
    logic     advance;
    logic     s_xfer;

    // Stage handshakes
    assign advance        = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready       = !in_valid_reg || advance;
    assign s_xfer         = s_tvalid && s_tready;
    assign in_valid_next  = s_xfer ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? 1'b1 : ((m_tready) ? 1'b0 : out_valid_reg);

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            flags_reg     <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) begin
                flags_reg <= exec_res.flags;
            end
        end
    end

    // Payload stages
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            in_req_reg <= alu_req_t'(s_tdata[$bits(alu_req_t)-1:0]);
        end
        if (advance) begin
            out_res_reg <= exec_res;
        end
    end

    xalu_exec u_exec (
        .req      (in_req_reg),
        .flags_in (flags_reg),
        .res      (exec_res)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - $bits(alu_res_t)){1'b0}}, out_res_reg};

endmodule

`default_nettype wire

// File: rtl/core/xalu_exec.sv
// Combinational ALU datapath: add/sub/logic result and 8086 flag generation.
// Depends on xalu_pkg.
`default_nettype none

module xalu_exec (
    input  xalu_pkg::alu_req_t req,
    input  xalu_pkg::flags_t   flags_in,
    output xalu_pkg::alu_res_t res
);
    import xalu_pkg::*;

    logic [DATA_W-1:0] mask;
    logic [DATA_W-1:0] sign;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    logic              cin;
    logic [DATA_W:0]   sum;
    logic [DATA_W:0]   diff;
    logic [DATA_W-1:0] add_res;
    logic [DATA_W-1:0] sub_res;
    logic              add_cf;
    logic              sub_cf;
    logic              is_incdec;
    logic [DATA_W-1:0] r;
    logic              arith;
    logic              logic_op;
    logic              cf;
    logic              af;
    logic              of;
    logic              wb;
    flags_t            fl;

    // Operand size selection
    assign mask      = req.wide ? 16'hFFFF : 16'h00FF;
    assign sign      = req.wide ? 16'h8000 : 16'h0080;
    assign is_incdec = (req.req_type == OP_INC) || (req.req_type == OP_DEC);
    assign a         = req.dst_value & mask;
    assign b         = is_incdec ? 16'h0001 : (req.src_value & mask);

    // Carry-in only for ADC/SBB
    assign cin = ((req.req_type == OP_ADC) || (req.req_type == OP_SBB)) ? flags_in.cf : 1'b0;

    // Shared adder and subtractor, carry taken at the operand size
    assign sum     = {1'b0, a} + {1'b0, b} + {{DATA_W{1'b0}}, cin};
    assign diff    = {1'b0, a} - {1'b0, b} - {{DATA_W{1'b0}}, cin};
    assign add_res = sum[DATA_W-1:0] & mask;
    assign sub_res = diff[DATA_W-1:0] & mask;
    assign add_cf  = req.wide ? sum[DATA_W]  : sum[8];
    assign sub_cf  = req.wide ? diff[DATA_W] : diff[8];

    // Operation select
    always_comb begin
        r        = a;
        arith    = 1'b0;
        logic_op = 1'b0;
        cf       = 1'b0;
        af       = 1'b0;
        of       = 1'b0;
        wb       = 1'b0;
        case (req.req_type)
            OP_ADD, OP_ADC, OP_INC: begin
                r     = add_res;
                cf    = add_cf;
                af    = (a[AF_BIT] ^ b[AF_BIT] ^ add_res[AF_BIT]);
                of    = |((a ^ add_res) & (b ^ add_res) & sign);
                arith = 1'b1;
                wb    = 1'b1;
            end
            OP_SBB, OP_SUB, OP_CMP, OP_DEC: begin
                r     = sub_res;
                cf    = sub_cf;
                af    = (a[AF_BIT] ^ b[AF_BIT] ^ sub_res[AF_BIT]);
                of    = |((a ^ b) & (a ^ sub_res) & sign);
                arith = 1'b1;
                wb    = (req.req_type != OP_CMP);
            end
            OP_OR: begin
                r        = a | b;
                logic_op = 1'b1;
                wb       = 1'b1;
            end
            OP_AND, OP_TEST: begin
                r        = a & b;
                logic_op = 1'b1;
                wb       = (req.req_type != OP_TEST);
            end
            OP_XOR: begin
                r        = a ^ b;
                logic_op = 1'b1;
                wb       = 1'b1;
            end
            default: begin
                r = a;
            end
        endcase
    end

    // Flag update; unused codes keep all flags
    always_comb begin
        fl = flags_in;
        if (arith || logic_op) begin
            fl.pf = ~(^r[7:0]);
            fl.zf = (r == '0);
            fl.sf = |(r & sign);
            if (logic_op) begin
                fl.cf = 1'b0;
                fl.of = 1'b0;
                fl.af = flags_in.af;
            end else begin
                fl.cf = is_incdec ? flags_in.cf : cf;
                fl.af = af;
                fl.of = of;
            end
        end
    end

    assign res.result     = r;
    assign res.write_back = wb;
    assign res.flags      = fl;

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// Self-checking testbench for x86_integer_alu_with_flags: directed corner cases, then
// random operations under several idle/stall mixes, checked against an in-bench flag model.
// Depends on xalu_pkg and the RTL top level only.

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import xalu_pkg::*;

    // Codes past OP_DEC are not operations; the block passes the destination through
    localparam logic [3:0] OP_UNUSED_LO = 4'd11;
    localparam logic [3:0] OP_UNUSED_HI = 4'd15;

    localparam int RAND_PER_PHASE = 460;
    localparam int NUM_PHASES     = 4;
    localparam int IDLE_LIMIT     = 1000;
    localparam int SETTLE_CYCLES  = 8;

    // One ALU request as queued for the driver
    typedef struct {
        logic [3:0]  op;
        logic        wide;
        logic [15:0] dst;
        logic [15:0] src;
        bit          after_drain;
    } alu_op_item_t;

    // Expected result transfer, same layout as m_tdata from bit 0
    typedef struct packed {
        flags_t      flags;
        logic        write_back;
        logic [15:0] result;
    } alu_outcome_t;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    wire                   s_tready;
    logic [S_TDATA_W-1:0]  s_tdata  = '0;
    wire                   m_tvalid;
    logic                  m_tready = 1'b0;
    wire  [M_TDATA_W-1:0]  m_tdata;

    alu_op_item_t queued_ops[$];
    alu_outcome_t pending_results[$];
    alu_op_item_t cur_item;
    flags_t       flag_state = '0;

    int gap_pct      = 0;
    int stall_pct    = 0;
    int fail_count   = 0;
    int result_count = 0;
    int idle_cycles  = 0;

    x86_integer_alu_with_flags dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // 4 ns clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Flag model: computes one result and updates flag_state
    function automatic alu_outcome_t alu_predict(input alu_op_item_t it);
        logic [16:0]  mask, sign, a, b, c, total, res;
        flags_t       fl, nf;
        logic         cf, af, of, wb, arith, logic_op, keep_cf;
        alu_outcome_t out;
        mask     = it.wide ? 17'h0FFFF : 17'h000FF;
        sign     = it.wide ? 17'h08000 : 17'h00080;
        a        = {1'b0, it.dst} & mask;
        b        = {1'b0, it.src} & mask;
        c        = '0;
        res      = a;
        fl       = flag_state;
        cf       = 1'b0;
        af       = 1'b0;
        of       = 1'b0;
        wb       = 1'b0;
        arith    = 1'b0;
        logic_op = 1'b0;
        keep_cf  = 1'b0;
        // inc/dec behave as add/sub of one, carry preserved
        if (it.op == OP_INC || it.op == OP_DEC) begin
            b       = 17'd1;
            keep_cf = 1'b1;
        end
        case (it.op)
            OP_ADD, OP_ADC, OP_INC: begin
                if (it.op == OP_ADC) c = {16'd0, flag_state.cf};
                total = a + b + c;
                res   = total & mask;
                cf    = total > mask;
                af    = ((a ^ b ^ res) & 17'h10) != 0;
                of    = ((a ^ res) & (b ^ res) & sign) != 0;
                arith = 1'b1;
                wb    = 1'b1;
            end
            OP_SBB, OP_SUB, OP_CMP, OP_DEC: begin
                if (it.op == OP_SBB) c = {16'd0, flag_state.cf};
                res   = (a - b - c) & mask;
                cf    = a < (b + c);
                af    = ((a ^ b ^ res) & 17'h10) != 0;
                of    = ((a ^ b) & (a ^ res) & sign) != 0;
                arith = 1'b1;
                wb    = (it.op != OP_CMP);
            end
            OP_OR: begin
                res      = a | b;
                logic_op = 1'b1;
                wb       = 1'b1;
            end
            OP_AND, OP_TEST: begin
                res      = a & b;
                logic_op = 1'b1;
                wb       = (it.op != OP_TEST);
            end
            OP_XOR: begin
                res      = a ^ b;
                logic_op = 1'b1;
                wb       = 1'b1;
            end
            default: ;
        endcase
        if (arith || logic_op) begin
            nf = '0;
            if (logic_op) begin
                nf.af = fl.af;
            end else begin
                nf.cf = keep_cf ? fl.cf : cf;
                nf.af = af;
                nf.of = of;
            end
            nf.pf      = ~^res[7:0];
            nf.zf      = (res == 0);
            nf.sf      = (res & sign) != 0;
            fl         = nf;
            flag_state = nf;
        end
        out.result     = res[15:0];
        out.write_back = wb;
        out.flags      = fl;
        return out;
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("mismatch on result %0d: %s got %h expected %h",
                 result_count, what, got, want);
        fail_count++;
    endtask

    // Compare one result transfer with the oldest expectation
    task automatic check_result(input logic [M_TDATA_W-1:0] word);
        alu_outcome_t got, want;
        got = alu_outcome_t'(word[$bits(alu_outcome_t)-1:0]);
        if (pending_results.size() == 0) begin
            report_mismatch("result with nothing pending", got.result, 16'h0);
        end else begin
            want = pending_results.pop_front();
            if (got.result !== want.result)
                report_mismatch("result", got.result, want.result);
            if (got.write_back !== want.write_back)
                report_mismatch("write_back", 16'(got.write_back), 16'(want.write_back));
            if (got.flags.cf !== want.flags.cf)
                report_mismatch("carry", 16'(got.flags.cf), 16'(want.flags.cf));
            if (got.flags.pf !== want.flags.pf)
                report_mismatch("parity", 16'(got.flags.pf), 16'(want.flags.pf));
            if (got.flags.af !== want.flags.af)
                report_mismatch("aux", 16'(got.flags.af), 16'(want.flags.af));
            if (got.flags.zf !== want.flags.zf)
                report_mismatch("zero", 16'(got.flags.zf), 16'(want.flags.zf));
            if (got.flags.sf !== want.flags.sf)
                report_mismatch("sign", 16'(got.flags.sf), 16'(want.flags.sf));
            if (got.flags.of !== want.flags.of)
                report_mismatch("overflow", 16'(got.flags.of), 16'(want.flags.of));
        end
        result_count++;
    endtask

    function automatic void queue_op(input logic [3:0] op, input logic wide,
                                     input logic [15:0] dst, input logic [15:0] src,
                                     input bit after_drain);
        alu_op_item_t it;
        it.op          = op;
        it.wide        = wide;
        it.dst         = dst;
        it.src         = src;
        it.after_drain = after_drain;
        queued_ops.push_back(it);
    endfunction

    // Operand values: boundary values a quarter of the time, else uniform
    function automatic logic [15:0] pick_value();
        logic [15:0] corners[8];
        corners = '{16'h0000, 16'h0001, 16'h007F, 16'h0080,
                    16'h00FF, 16'h7FFF, 16'h8000, 16'hFFFF};
        if ($urandom_range(3, 0) == 0)
            return corners[$urandom_range(7, 0)];
        return 16'($urandom_range(16'hFFFF, 0));
    endfunction

    // Input side driver: predicts on each transfer, then offers the next item
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid   <= 1'b0;
            s_tdata    <= '0;
            flag_state = '0;
        end else begin
            if (s_tvalid && s_tready)
                pending_results.push_back(alu_predict(cur_item));
            if (!s_tvalid || s_tready) begin
                if (queued_ops.size() != 0 && $urandom_range(99, 0) >= gap_pct &&
                    (!queued_ops[0].after_drain || pending_results.size() == 0)) begin
                    cur_item = queued_ops.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= S_TDATA_W'({cur_item.src, cur_item.dst, cur_item.wide,
                                            cur_item.op});
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result side: check transfers, stall at random
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready)
                check_result(m_tdata);
            m_tready <= ($urandom_range(99, 0) >= stall_pct);
        end
    end

    // Watchdog: cycles with no transfer on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Stimulus
    initial begin
        alu_op_item_t it;
        int           phase_gap[NUM_PHASES];
        int           phase_stall[NUM_PHASES];
        phase_gap   = '{0, 56, 0, 37};
        phase_stall = '{0, 0, 56, 37};

        // carry out, zero, nibble carry, then adc consumes the carry
        queue_op(OP_ADD, 1'b0, 16'h12FF, 16'hAB01, 1'b0);
        queue_op(OP_ADC, 1'b0, 16'h007F, 16'h0000, 1'b0);
        queue_op(OP_ADD, 1'b1, 16'h7FFF, 16'h0001, 1'b0);
        queue_op(OP_ADD, 1'b1, 16'hFFFF, 16'hFFFF, 1'b0);
        queue_op(OP_ADC, 1'b1, 16'hFFFF, 16'hFFFF, 1'b0);
        // borrow and signed overflow on subtraction
        queue_op(OP_SUB, 1'b0, 16'hFF00, 16'h0001, 1'b0);
        queue_op(OP_SBB, 1'b1, 16'h0000, 16'hFFFF, 1'b0);
        queue_op(OP_SUB, 1'b1, 16'h8000, 16'h0001, 1'b0);
        queue_op(OP_SBB, 1'b0, 16'h0080, 16'h007F, 1'b0);
        // compare keeps the destination
        queue_op(OP_CMP, 1'b0, 16'h0080, 16'h0080, 1'b0);
        queue_op(OP_CMP, 1'b1, 16'h0000, 16'h8000, 1'b0);
        // logic ops: carry/overflow cleared, aux carried over
        queue_op(OP_ADD, 1'b0, 16'h000F, 16'h0001, 1'b0);
        queue_op(OP_OR,  1'b0, 16'h00F0, 16'h000F, 1'b0);
        queue_op(OP_AND, 1'b1, 16'hFFFF, 16'h8001, 1'b0);
        queue_op(OP_XOR, 1'b1, 16'hA5A5, 16'hA5A5, 1'b0);
        queue_op(OP_TEST, 1'b0, 16'hFF80, 16'h0080, 1'b0);
        // inc/dec leave the carry alone
        queue_op(OP_SUB, 1'b0, 16'h0000, 16'h0001, 1'b0);
        queue_op(OP_INC, 1'b0, 16'h00FF, 16'hFFFF, 1'b0);
        queue_op(OP_INC, 1'b1, 16'h7FFF, 16'h0000, 1'b0);
        queue_op(OP_DEC, 1'b0, 16'h0000, 16'h1234, 1'b0);
        queue_op(OP_DEC, 1'b1, 16'h8000, 16'h0000, 1'b0);
        // codes past the last operation
        queue_op(OP_UNUSED_LO, 1'b0, 16'hBEEF, 16'h1111, 1'b0);
        queue_op(OP_UNUSED_HI, 1'b1, 16'hBEEF, 16'h2222, 1'b0);

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        for (int p = 0; p < NUM_PHASES; p++) begin
            @(negedge aclk);
            gap_pct   = phase_gap[p];
            stall_pct = phase_stall[p];
            for (int n = 0; n < RAND_PER_PHASE; n++) begin
                if ($urandom_range(9, 0) == 0)
                    it.op = 4'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
                else
                    it.op = 4'($urandom_range(OP_DEC, OP_ADD));
                it.wide = 1'($urandom_range(1, 0));
                queue_op(it.op, it.wide, pick_value(), pick_value(),
                         n == 0 || n == RAND_PER_PHASE / 2);
            end
            while (queued_ops.size() != 0)
                @(negedge aclk);
        end

        // all items taken, then all results back
        while (queued_ops.size() != 0 || s_tvalid)
            @(negedge aclk);
        while (pending_results.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);

        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
